// File: hdl/tmab_pkg.sv
// Package for the triangle mesh adjacency builder.
// Holds sizes, command, error and register codes, the state enum and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none
package tmab_pkg;
    localparam int MaxVerts = 128;
    localparam int MaxTris  = 64;
    localparam int EdgeCap  = 3 * MaxTris;
    localparam int VW = $clog2(MaxVerts);
    localparam int TW = $clog2(MaxTris);
    localparam int EW = $clog2(EdgeCap);

    localparam logic [1:0] CMD_VERT   = 2'd0;
    localparam logic [1:0] CMD_TRI    = 2'd1;
    localparam logic [1:0] CMD_FINISH = 2'd2;

    localparam logic [2:0] ERR_OK       = 3'd0;
    localparam logic [2:0] ERR_EMPTY    = 3'd1;
    localparam logic [2:0] ERR_POLYS    = 3'd2;
    localparam logic [2:0] ERR_INDEX    = 3'd3;
    localparam logic [2:0] ERR_DEGEN    = 3'd4;
    localparam logic [2:0] ERR_NONMANI  = 3'd5;
    localparam logic [2:0] ERR_VERTS    = 3'd6;

    localparam logic REG_POLY_LIMIT = 1'b0;
    localparam logic REG_EPSILON    = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE, S_PRECHK, S_TRD, S_VRD, S_VRB, S_VRC, S_MUL, S_AREA, S_EDGE, S_SCAN,
        S_EUPD, S_ERR, S_ORD, S_OEDGE, S_OSCAN, S_OEMIT, S_CLEAR
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic       tri_rd;      // read triangle r_tri_idx
        logic       vert_rd;     // read one vertex of the triangle
        logic [1:0] vert_sel;    // which vertex: a, b or c
        logic       mul;         // form products
        logic       area;        // difference and compare
        logic       edge_start;  // load key for edge r_edge_sel, reset scan
        logic       scan_step;   // read or compare one table entry
        logic       edge_upd;    // append or bump entry
        logic       next_edge;
        logic       next_tri;
        logic       rewind;      // zero triangle index, edge select and, without edge_upd, edge tally
        logic       emit_err;
        logic       emit_ok;
        logic       clear;       // tallies back to zero
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic [2:0] pre_err;   // empty/verts/polys check
        logic       bad_idx;
        logic       repeat_v;
        logic       degen;
        logic       scan_done; // scan reached tally or found
        logic       found;
        logic       full_edge; // found entry already has two
        logic       last_edge;
        logic       last_tri;
    } t_stat;
endpackage
`default_nettype wire

// File: hdl/tmab_ctrl.sv
// Controller state machine of the adjacency builder.
// Depends on tmab_pkg (state enum, command and status structs).
`default_nettype none
module tmab_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_go,
    input  wire tmab_pkg::t_stat  i_stat,
    output tmab_pkg::t_cmd        o_cmd,
    output logic                  o_busy,
    output logic [2:0]            o_err
);
    tmab_pkg::t_state r_state, n_state;
    logic [2:0] r_err, n_err;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tmab_pkg::S_IDLE;
            r_err   <= tmab_pkg::ERR_OK;
        end else begin
            r_state <= n_state;
            r_err   <= n_err;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_err   = r_err;
        unique case (r_state)
            tmab_pkg::S_IDLE: if (i_go) n_state = tmab_pkg::S_PRECHK;
            tmab_pkg::S_PRECHK: begin
                n_err = i_stat.pre_err;
                n_state = (i_stat.pre_err != tmab_pkg::ERR_OK) ? tmab_pkg::S_ERR
                                                               : tmab_pkg::S_TRD;
            end
            tmab_pkg::S_TRD: n_state = tmab_pkg::S_VRD;
            tmab_pkg::S_VRD: begin
                if (i_stat.bad_idx) begin
                    n_err = tmab_pkg::ERR_INDEX; n_state = tmab_pkg::S_ERR;
                end else if (i_stat.repeat_v) begin
                    n_err = tmab_pkg::ERR_DEGEN; n_state = tmab_pkg::S_ERR;
                end else n_state = tmab_pkg::S_VRB;
            end
            tmab_pkg::S_VRB:  n_state = tmab_pkg::S_VRC;
            tmab_pkg::S_VRC:  n_state = tmab_pkg::S_MUL;
            tmab_pkg::S_MUL:  n_state = tmab_pkg::S_AREA;
            tmab_pkg::S_AREA: begin
                if (i_stat.degen) begin
                    n_err = tmab_pkg::ERR_DEGEN; n_state = tmab_pkg::S_ERR;
                end else n_state = tmab_pkg::S_EDGE;
            end
            tmab_pkg::S_EDGE: n_state = tmab_pkg::S_SCAN;
            tmab_pkg::S_SCAN: if (i_stat.scan_done) n_state = tmab_pkg::S_EUPD;
            tmab_pkg::S_EUPD: begin
                if (i_stat.found && i_stat.full_edge) begin
                    n_err = tmab_pkg::ERR_NONMANI; n_state = tmab_pkg::S_ERR;
                end else if (!i_stat.last_edge) n_state = tmab_pkg::S_EDGE;
                else if (!i_stat.last_tri) n_state = tmab_pkg::S_TRD;
                else n_state = tmab_pkg::S_ORD;
            end
            tmab_pkg::S_ERR:   n_state = tmab_pkg::S_CLEAR;
            tmab_pkg::S_ORD:   n_state = tmab_pkg::S_OEDGE;
            tmab_pkg::S_OEDGE: n_state = tmab_pkg::S_OSCAN;
            tmab_pkg::S_OSCAN: begin
                if (i_stat.scan_done)
                    n_state = i_stat.last_edge ? tmab_pkg::S_OEMIT : tmab_pkg::S_OEDGE;
            end
            tmab_pkg::S_OEMIT:
                n_state = i_stat.last_tri ? tmab_pkg::S_CLEAR : tmab_pkg::S_ORD;
            tmab_pkg::S_CLEAR: n_state = tmab_pkg::S_IDLE;
            default: n_state = tmab_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            tmab_pkg::S_PRECHK: o_cmd.rewind = 1'b1;
            tmab_pkg::S_TRD:    o_cmd.tri_rd = 1'b1;
            tmab_pkg::S_VRD: begin
                o_cmd.vert_rd  = 1'b1;
                o_cmd.vert_sel = 2'd0;
            end
            tmab_pkg::S_VRB: begin
                o_cmd.vert_rd  = 1'b1;
                o_cmd.vert_sel = 2'd1;
            end
            tmab_pkg::S_VRC: begin
                o_cmd.vert_rd  = 1'b1;
                o_cmd.vert_sel = 2'd2;
            end
            tmab_pkg::S_MUL:    o_cmd.mul = 1'b1;
            tmab_pkg::S_AREA:   o_cmd.area = 1'b1;
            tmab_pkg::S_EDGE:   o_cmd.edge_start = 1'b1;
            tmab_pkg::S_SCAN:   o_cmd.scan_step = 1'b1;
            tmab_pkg::S_EUPD: begin
                o_cmd.edge_upd  = 1'b1;
                o_cmd.next_edge = 1'b1;
                o_cmd.next_tri  = i_stat.last_edge;
                o_cmd.rewind    = i_stat.last_edge && i_stat.last_tri;
            end
            tmab_pkg::S_ERR:   o_cmd.emit_err = 1'b1;
            tmab_pkg::S_ORD:   o_cmd.tri_rd = 1'b1;
            tmab_pkg::S_OEDGE: o_cmd.edge_start = 1'b1;
            tmab_pkg::S_OSCAN: begin
                o_cmd.scan_step = 1'b1;
                o_cmd.next_edge = i_stat.scan_done;
            end
            tmab_pkg::S_OEMIT: begin
                o_cmd.emit_ok  = 1'b1;
                o_cmd.next_tri = 1'b1;
            end
            tmab_pkg::S_CLEAR: o_cmd.clear = 1'b1;
            default: ;
        endcase
    end

    assign o_busy = (r_state != tmab_pkg::S_IDLE);
    assign o_err  = r_err;

    // an error result only follows a nonzero error code
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmab_pkg::S_ERR) |-> (r_err != tmab_pkg::ERR_OK))
        else $error("error emitted with ok code");
    // an error result always passes on to the clearing step
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmab_pkg::S_ERR) |=> (r_state == tmab_pkg::S_CLEAR))
        else $error("error not followed by clear");
    // idle is only left on a finish request
    a_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tmab_pkg::S_IDLE && !i_go) |=> (r_state == tmab_pkg::S_IDLE))
        else $error("left idle without request");
endmodule
`default_nettype wire

// File: hdl/tmab_datapath.sv
// Datapath of the adjacency builder: vertex, triangle and edge stores,
// tallies, area arithmetic and result registers. Depends on tmab_pkg.
`default_nettype none
module tmab_datapath (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_load_vert,
    input  wire                   i_load_tri,
    input  wire  signed [30:0]    i_vert_x,
    input  wire  signed [30:0]    i_vert_z,
    input  wire  [7:0]            i_tri_a,
    input  wire  [7:0]            i_tri_b,
    input  wire  [7:0]            i_tri_c,
    input  wire  [7:0]            i_area_tag,
    input  wire  [6:0]            i_poly_limit,
    input  wire  [31:0]           i_area_epsilon,
    input  wire  [2:0]            i_err,
    input  wire tmab_pkg::t_cmd   i_cmd,
    output tmab_pkg::t_stat       o_stat,
    output logic                  o_valid,
    output logic [5:0]            o_poly_index,
    output logic [7:0]            o_poly_area_tag,
    output logic [5:0]            o_neighbor_0,
    output logic [5:0]            o_neighbor_1,
    output logic [5:0]            o_neighbor_2,
    output logic [2:0]            o_neighbor_present,
    output logic [2:0]            o_error,
    output logic                  o_last
);
    localparam int VW = tmab_pkg::VW;
    localparam int TW = tmab_pkg::TW;
    localparam int EW = tmab_pkg::EW;

    // memories
    logic signed [30:0] m_vx [tmab_pkg::MaxVerts];
    logic signed [30:0] m_vz [tmab_pkg::MaxVerts];
    logic [31:0]        m_tri [tmab_pkg::MaxTris];
    logic [13:0]        m_key [tmab_pkg::EdgeCap];
    logic [13:0]        m_rec [tmab_pkg::EdgeCap];

    logic [VW:0]   r_vtally;
    logic          r_vovf;
    logic [TW:0]   r_ttally;
    logic [EW:0]   r_etally;
    logic [TW-1:0] r_tri_idx;
    logic [1:0]    r_edge_sel;
    logic [EW:0]   r_scan;
    logic          r_found;
    logic [EW-1:0] r_hit;
    logic          r_scan_rd;   // key read in flight
    logic [31:0]   r_tri;
    logic [13:0]   r_key;
    logic [13:0]   r_key_rd, r_rec_rd;
    logic [7:0]    r_ia, r_ib, r_ic;

    // tri fields and edge key of the selected edge
    logic [7:0] w_p, w_q, w_lo, w_hi;
    always_comb begin
        unique case (r_edge_sel)
            2'd0:    begin w_p = r_ia; w_q = r_ib; end
            2'd1:    begin w_p = r_ib; w_q = r_ic; end
            default: begin w_p = r_ic; w_q = r_ia; end
        endcase
        w_lo = (w_p < w_q) ? w_p : w_q;
        w_hi = (w_p < w_q) ? w_q : w_p;
    end

    // load path and tallies
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vtally <= '0; r_vovf <= 1'b0; r_ttally <= '0;
        end else if (i_cmd.clear) begin
            r_vtally <= '0; r_vovf <= 1'b0; r_ttally <= '0;
        end else begin
            if (i_load_vert) begin
                if (r_vtally < (VW+1)'(tmab_pkg::MaxVerts)) r_vtally <= r_vtally + 1'b1;
                else r_vovf <= 1'b1;
            end
            if (i_load_tri && r_ttally < (TW+1)'(tmab_pkg::MaxTris + 1))
                r_ttally <= r_ttally + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load_vert && r_vtally < (VW+1)'(tmab_pkg::MaxVerts)) begin
            m_vx[r_vtally[VW-1:0]] <= i_vert_x;
            m_vz[r_vtally[VW-1:0]] <= i_vert_z;
        end
        if (i_load_tri && r_ttally < (TW+1)'(tmab_pkg::MaxTris))
            m_tri[r_ttally[TW-1:0]] <= {i_area_tag, i_tri_c, i_tri_b, i_tri_a};
    end

    // vertex address of the current read
    logic [VW-1:0] w_vaddr;
    always_comb begin
        case (i_cmd.vert_sel)
            2'd0:    w_vaddr = r_ia[VW-1:0];
            2'd1:    w_vaddr = r_ib[VW-1:0];
            default: w_vaddr = r_ic[VW-1:0];
        endcase
    end

    // triangle read, then one vertex per cycle
    logic signed [30:0] r_ax, r_az, r_bx, r_bz, r_cx, r_cz;
    always_ff @(posedge i_clk) begin
        if (i_cmd.tri_rd) r_tri <= m_tri[r_tri_idx];
        if (i_cmd.vert_rd) begin
            case (i_cmd.vert_sel)
                2'd0:    begin r_ax <= m_vx[w_vaddr]; r_az <= m_vz[w_vaddr]; end
                2'd1:    begin r_bx <= m_vx[w_vaddr]; r_bz <= m_vz[w_vaddr]; end
                default: begin r_cx <= m_vx[w_vaddr]; r_cz <= m_vz[w_vaddr]; end
            endcase
        end
    end
    assign r_ia = r_tri[7:0];
    assign r_ib = r_tri[15:8];
    assign r_ic = r_tri[23:16];

    // area: 32x32 signed products, then difference and magnitude compare
    logic signed [31:0] w_ux, w_uz, w_vx, w_vz;
    logic signed [63:0] r_p1, r_p2;
    assign w_ux = 32'(r_bx) - 32'(r_ax);
    assign w_uz = 32'(r_bz) - 32'(r_az);
    assign w_vx = 32'(r_cx) - 32'(r_ax);
    assign w_vz = 32'(r_cz) - 32'(r_az);
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_p1 <= w_ux * w_vz;
            r_p2 <= w_uz * w_vx;
        end
    end
    logic signed [63:0] w_d;
    logic [63:0] w_mag;
    assign w_d   = r_p1 - r_p2;
    assign w_mag = w_d[63] ? 64'(-w_d) : 64'(w_d);

    // status to the controller
    logic [6:0] w_limit;
    always_comb begin
        w_limit = (i_poly_limit > 7'(tmab_pkg::MaxTris)) ? 7'(tmab_pkg::MaxTris)
                                                        : i_poly_limit;
        o_stat = '0;
        if (r_vtally == '0 || r_ttally == '0) o_stat.pre_err = tmab_pkg::ERR_EMPTY;
        else if (r_vovf) o_stat.pre_err = tmab_pkg::ERR_VERTS;
        else if (7'(r_ttally) > w_limit) o_stat.pre_err = tmab_pkg::ERR_POLYS;
        else o_stat.pre_err = tmab_pkg::ERR_OK;
        o_stat.bad_idx   = ({1'b0, r_ia} >= 9'(r_vtally)) ||
                           ({1'b0, r_ib} >= 9'(r_vtally)) ||
                           ({1'b0, r_ic} >= 9'(r_vtally));
        o_stat.repeat_v  = (r_ia == r_ib) || (r_ib == r_ic) || (r_ia == r_ic);
        o_stat.degen     = i_cmd.area && (w_mag <= {32'd0, i_area_epsilon});
        o_stat.scan_done = r_found || (r_scan >= r_etally);
        o_stat.found     = r_found;
        o_stat.full_edge = (r_rec_rd[13:12] >= 2'd2);
        o_stat.last_edge = (r_edge_sel == 2'd2);
        o_stat.last_tri  = ((TW+1)'(r_tri_idx) + 1'b1 == r_ttally);
    end

    // edge table scan: each entry takes a read step, then a compare step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etally <= '0; r_tri_idx <= '0; r_edge_sel <= '0;
            r_scan <= '0; r_found <= 1'b0; r_scan_rd <= 1'b0;
        end else begin
            if (i_cmd.clear) r_etally <= '0;
            if (i_cmd.edge_start) begin
                r_key <= {w_lo[6:0], w_hi[6:0]};
                r_scan <= '0; r_found <= 1'b0; r_scan_rd <= 1'b0;
            end
            if (i_cmd.scan_step && !o_stat.scan_done) begin
                if (!r_scan_rd) begin
                    r_key_rd <= m_key[r_scan[EW-1:0]];
                    r_rec_rd <= m_rec[r_scan[EW-1:0]];
                    r_scan_rd <= 1'b1;
                end else begin
                    r_scan_rd <= 1'b0;
                    if (r_key_rd == r_key) begin
                        r_found <= 1'b1;
                        r_hit <= r_scan[EW-1:0];
                    end else r_scan <= r_scan + 1'b1;
                end
            end
            if (i_cmd.edge_upd) begin
                if (!r_found && r_etally < (EW+1)'(tmab_pkg::EdgeCap)) begin
                    m_key[r_etally[EW-1:0]] <= r_key;
                    m_rec[r_etally[EW-1:0]] <= {2'd1, 6'd0, r_tri_idx};
                    r_etally <= r_etally + 1'b1;
                end else if (r_found && r_rec_rd[13:12] < 2'd2)
                    m_rec[r_hit] <= {2'd2, r_tri_idx, r_rec_rd[5:0]};
            end
            if (i_cmd.rewind) begin
                r_tri_idx <= '0; r_edge_sel <= '0;
            end else begin
                if (i_cmd.next_edge)
                    r_edge_sel <= (r_edge_sel == 2'd2) ? 2'd0 : r_edge_sel + 1'b1;
                if (i_cmd.next_tri) r_tri_idx <= r_tri_idx + 1'b1;
            end
            if (i_cmd.rewind && !i_cmd.edge_upd) r_etally <= '0;
        end
    end

    // neighbor of the scanned edge
    logic [5:0] w_nb;
    logic       w_np;
    always_comb begin
        w_nb = '0; w_np = 1'b0;
        if (r_found) begin
            if (r_rec_rd[13:12] >= 2'd1 && r_rec_rd[5:0] != 6'(r_tri_idx)) begin
                w_nb = r_rec_rd[5:0]; w_np = 1'b1;
            end else if (r_rec_rd[13:12] >= 2'd2 && r_rec_rd[11:6] != 6'(r_tri_idx)) begin
                w_nb = r_rec_rd[11:6]; w_np = 1'b1;
            end
        end
    end

    logic [5:0] r_nb [3];
    logic [2:0] r_np;
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_step && o_stat.scan_done) begin
            r_nb[r_edge_sel] <= w_nb;
            r_np[r_edge_sel] <= w_np;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= i_cmd.emit_err || i_cmd.emit_ok;
        if (i_cmd.emit_err) begin
            o_poly_index <= '0; o_poly_area_tag <= '0;
            o_neighbor_0 <= '0; o_neighbor_1 <= '0; o_neighbor_2 <= '0;
            o_neighbor_present <= '0; o_error <= i_err; o_last <= 1'b1;
        end else if (i_cmd.emit_ok) begin
            o_poly_index <= 6'(r_tri_idx); o_poly_area_tag <= r_tri[31:24];
            o_neighbor_0 <= r_nb[0]; o_neighbor_1 <= r_nb[1]; o_neighbor_2 <= r_nb[2];
            o_neighbor_present <= r_np; o_error <= tmab_pkg::ERR_OK;
            o_last <= o_stat.last_tri;
        end
    end

    // the edge tally never exceeds the table
    a_etally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_etally <= (EW+1)'(tmab_pkg::EdgeCap)) else $error("edge tally overflow");
    // a hit used for an update lies inside the filled table
    a_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.edge_upd && r_found) |-> ((EW+1)'(r_hit) < r_etally))
        else $error("hit beyond tally");
    // the triangle tally saturates one past capacity
    a_ttally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ttally <= (TW+1)'(tmab_pkg::MaxTris + 1)) else $error("tri tally overflow");
endmodule
`default_nettype wire

// File: hdl/triangle_mesh_adjacency_builder.sv
// Top level of the triangle mesh adjacency builder: config registers,
// controller and datapath. Depends on tmab_pkg, tmab_ctrl, tmab_datapath.
// Loads (vertex, triangle): one per cycle while not busy. Finish: a check,
// then per triangle a read of it and its vertices, products, an area test
// and per edge a key load, scan and update; then per triangle a read, per
// edge a scan and one result; then a clear. An error ends the pass early.
// Reset clears tallies and state; results are one-cycle strobes, no stall.
`default_nettype none
module triangle_mesh_adjacency_builder (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  wire               i_cfg_we,
    input  wire  [0:0]        i_cfg_index,
    input  wire  [31:0]       i_cfg_data,
    input  wire  [1:0]        i_cmd,
    input  wire signed [30:0] i_vert_x,
    input  wire signed [30:0] i_vert_z,
    input  wire  [7:0]        i_tri_a,
    input  wire  [7:0]        i_tri_b,
    input  wire  [7:0]        i_tri_c,
    input  wire  [7:0]        i_area_tag,
    output logic              o_strobe,
    output logic [5:0]        o_poly_index,
    output logic [7:0]        o_poly_area_tag,
    output logic [5:0]        o_neighbor_0,
    output logic [5:0]        o_neighbor_1,
    output logic [5:0]        o_neighbor_2,
    output logic [2:0]        o_neighbor_present,
    output logic [2:0]        o_error,
    output logic              o_last
);
    logic [6:0]  r_poly_limit;
    logic [31:0] r_area_epsilon;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly_limit   <= 7'd64;
            r_area_epsilon <= 32'd4295;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tmab_pkg::REG_POLY_LIMIT: r_poly_limit   <= i_cfg_data[6:0];
                tmab_pkg::REG_EPSILON:    r_area_epsilon <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic w_acc;
    assign w_acc = start && !busy;

    tmab_pkg::t_cmd  w_cmd;
    tmab_pkg::t_stat w_stat;
    logic [2:0]      w_err;

    tmab_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_acc && i_cmd == tmab_pkg::CMD_FINISH),
        .i_stat (w_stat),
        .o_cmd  (w_cmd),
        .o_busy (busy),
        .o_err  (w_err)
    );

    tmab_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_load_vert       (w_acc && i_cmd == tmab_pkg::CMD_VERT),
        .i_load_tri        (w_acc && i_cmd == tmab_pkg::CMD_TRI),
        .i_vert_x          (i_vert_x),
        .i_vert_z          (i_vert_z),
        .i_tri_a           (i_tri_a),
        .i_tri_b           (i_tri_b),
        .i_tri_c           (i_tri_c),
        .i_area_tag        (i_area_tag),
        .i_poly_limit      (r_poly_limit),
        .i_area_epsilon    (r_area_epsilon),
        .i_err             (w_err),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .o_valid           (o_strobe),
        .o_poly_index      (o_poly_index),
        .o_poly_area_tag   (o_poly_area_tag),
        .o_neighbor_0      (o_neighbor_0),
        .o_neighbor_1      (o_neighbor_1),
        .o_neighbor_2      (o_neighbor_2),
        .o_neighbor_present(o_neighbor_present),
        .o_error           (o_error),
        .o_last            (o_last)
    );
endmodule
`default_nettype wire
